/* design/lzhc_pkg.sv */
// ----------------------------------------------------------------------------
// lzhc_pkg
// Shared constants, operation codes and helpers for the LZ77 hash-chain table.
// ----------------------------------------------------------------------------
package lzhc_pkg;

  // Default hash geometry
  localparam int HASH_WIDTH = 15;
  localparam int MATCH_MIN  = 3;

  // Field widths of one beat
  localparam int POS_W  = 16;
  localparam int HASH_W = 15;
  localparam int BYTE_W = 8;

  // Sliding window: prev table is indexed by position mod WINDOW_SIZE
  localparam int WIN_AW      = 15;
  localparam int WINDOW_SIZE = 1 << WIN_AW;

  // Operation codes
  typedef logic [1:0] func_t;
  localparam func_t FUNC_HASH   = 2'd0;
  localparam func_t FUNC_INSERT = 2'd1;
  localparam func_t FUNC_NEXT   = 2'd2;
  localparam func_t FUNC_SLIDE  = 2'd3;

  // Lower an entry by one window; anything below the window drops to end of chain
  function automatic logic [POS_W-1:0] slide_entry(input logic [POS_W-1:0] v);
    logic [POS_W-1:0] r;
    r = v[POS_W-1] ? {1'b0, v[POS_W-2:0]} : '0;
    return r;
  endfunction

endpackage

/* design/lzhc_ram.sv */
// ----------------------------------------------------------------------------
// lzhc_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lzhc_ram #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/lz77_hash_chain_table.sv */
// ----------------------------------------------------------------------------
// lz77_hash_chain_table
// Hash-chain index for an LZ77 match finder: head and prev tables in RAM.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass (one prev entry and one head
// entry per cycle) with in_stall held high. Hash-only, insert and
// next-in-chain beats are taken in the idle state, where the table RAMs are
// read; in the execute state, once the output register is free, the result
// is registered and any insert write-back is done. A slide sweeps both
// tables read-modify-write, one entry per cycle, then goes to the execute
// state, where its result beat is registered. The result register lets
// the next beat be taken while a finished result still waits.
// ----------------------------------------------------------------------------
module lz77_hash_chain_table #(
  parameter int HASH_WIDTH = lzhc_pkg::HASH_WIDTH,
  parameter int MATCH_MIN  = lzhc_pkg::MATCH_MIN
) (
  input  logic                         clk,
  input  logic                         rst,
  // Input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  lzhc_pkg::func_t              func,
  input  logic [lzhc_pkg::BYTE_W-1:0]  data_byte,
  input  logic [lzhc_pkg::POS_W-1:0]   position,
  input  logic [lzhc_pkg::HASH_W-1:0]  prev_hash,
  input  logic [lzhc_pkg::POS_W-1:0]   chain_pos,
  // Output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lzhc_pkg::POS_W-1:0]   found_pos,
  output logic [lzhc_pkg::HASH_W-1:0]  hash_out
);

  localparam int ROLL_SHIFT = (HASH_WIDTH + MATCH_MIN - 1) / MATCH_MIN;
  localparam int HEAD_DEPTH = 1 << HASH_WIDTH;
  localparam int WIN_AW     = lzhc_pkg::WIN_AW;
  localparam int CNT_W      = WIN_AW + 1;
  localparam int POS_W      = lzhc_pkg::POS_W;
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(lzhc_pkg::WINDOW_SIZE);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(lzhc_pkg::WINDOW_SIZE - 1);
  localparam logic [CNT_W-1:0] HEAD_LIM = CNT_W'(HEAD_DEPTH);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EXEC  = 4'b0100,
    S_SLIDE = 4'b1000
  } state_t;

  state_t state;

  logic [CNT_W-1:0]      cnt;
  logic                  wr_pend;
  logic [WIN_AW-1:0]     wr_addr;

  // Held beat
  lzhc_pkg::func_t       item_func;
  logic [POS_W-1:0]      item_pos;
  logic [HASH_WIDTH-1:0] item_hash;
  logic [WIN_AW-1:0]     item_chain;

  logic                  in_accept;
  logic                  out_free;
  logic [31:0]           roll_full;
  logic [HASH_WIDTH-1:0] hash_in;

  // RAM ports
  logic                  head_we;
  logic [HASH_WIDTH-1:0] head_waddr;
  logic [POS_W-1:0]      head_wdata;
  logic [HASH_WIDTH-1:0] head_raddr;
  logic [POS_W-1:0]      head_rdata;
  logic                  prev_we;
  logic [WIN_AW-1:0]     prev_waddr;
  logic [POS_W-1:0]      prev_wdata;
  logic [WIN_AW-1:0]     prev_raddr;
  logic [POS_W-1:0]      prev_rdata;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Rolling hash of the incoming beat
  assign roll_full = (32'(prev_hash) << ROLL_SHIFT) ^ 32'(data_byte);
  assign hash_in   = roll_full[HASH_WIDTH-1:0];

  // Read address select
  always_comb begin
    case (state)
      S_IDLE: begin
        head_raddr = hash_in;
        prev_raddr = chain_pos[WIN_AW-1:0];
      end
      S_SLIDE: begin
        head_raddr = cnt[HASH_WIDTH-1:0];
        prev_raddr = cnt[WIN_AW-1:0];
      end
      default: begin
        head_raddr = item_hash;
        prev_raddr = item_chain;
      end
    endcase
  end

  // Write port select: clearing pass, slide sweep, or insert write-back
  always_comb begin
    head_we    = 1'b0;
    head_waddr = item_hash;
    head_wdata = item_pos;
    prev_we    = 1'b0;
    prev_waddr = item_pos[WIN_AW-1:0];
    prev_wdata = head_rdata;
    case (state)
      S_CLEAR: begin
        prev_we    = 1'b1;
        prev_waddr = cnt[WIN_AW-1:0];
        prev_wdata = '0;
        head_we    = (cnt < HEAD_LIM);
        head_waddr = cnt[HASH_WIDTH-1:0];
        head_wdata = '0;
      end
      S_SLIDE: begin
        prev_we    = wr_pend;
        prev_waddr = wr_addr;
        prev_wdata = lzhc_pkg::slide_entry(prev_rdata);
        head_we    = wr_pend && (CNT_W'(wr_addr) < HEAD_LIM);
        head_waddr = wr_addr[HASH_WIDTH-1:0];
        head_wdata = lzhc_pkg::slide_entry(head_rdata);
      end
      S_EXEC: begin
        prev_we = out_free && (item_func == lzhc_pkg::FUNC_INSERT);
        head_we = out_free && (item_func == lzhc_pkg::FUNC_INSERT);
      end
      default: begin
      end
    endcase
  end

  lzhc_ram #(
    .DEPTH (HEAD_DEPTH),
    .AW    (HASH_WIDTH),
    .DW    (POS_W)
  ) u_head (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .raddr (head_raddr),
    .rdata (head_rdata)
  );

  lzhc_ram #(
    .DEPTH (lzhc_pkg::WINDOW_SIZE),
    .AW    (WIN_AW),
    .DW    (POS_W)
  ) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (prev_raddr),
    .rdata (prev_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      wr_pend <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (cnt == CNT_LAST) begin
            cnt   <= '0;
            state <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_accept) begin
            cnt     <= '0;
            wr_pend <= 1'b0;
            state   <= (func == lzhc_pkg::FUNC_SLIDE) ? S_SLIDE : S_EXEC;
          end
        end
        S_SLIDE: begin
          if (cnt == CNT_END) begin
            wr_pend <= 1'b0;
            state   <= S_EXEC;
          end else begin
            cnt     <= cnt + 1'b1;
            wr_pend <= 1'b1;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Sweep write address is the registered read address
  always_ff @(posedge clk) begin
    wr_addr <= cnt[WIN_AW-1:0];
  end

  // Beat capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_func  <= func;
      item_pos   <= position;
      item_hash  <= hash_in;
      item_chain <= chain_pos[WIN_AW-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EXEC && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC && out_free) begin
      case (item_func)
        lzhc_pkg::FUNC_HASH: begin
          found_pos <= '0;
          hash_out  <= lzhc_pkg::HASH_W'(item_hash);
        end
        lzhc_pkg::FUNC_INSERT: begin
          found_pos <= head_rdata;
          hash_out  <= lzhc_pkg::HASH_W'(item_hash);
        end
        lzhc_pkg::FUNC_NEXT: begin
          found_pos <= prev_rdata;
          hash_out  <= '0;
        end
        default: begin
          found_pos <= '0;
          hash_out  <= '0;
        end
      endcase
    end
  end

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("state register not one-hot");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    (in_accept && func != lzhc_pkg::FUNC_SLIDE) |=> (state == S_EXEC))
    else $error("non-slide beat did not go to execute");

  a_exec_write_insert: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && (head_we || prev_we)) |-> (item_func == lzhc_pkg::FUNC_INSERT))
    else $error("table write in execute for a non-insert beat");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result raised outside execute");

  a_sweep_write_in_slide: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> (state == S_SLIDE))
    else $error("sweep write pending outside slide");

endmodule
